// ===== hw/rtl/vrt_pkg.sv =====
// Shared types, constants and helpers of the trace ring unit.
package vrt_pkg;

  localparam int unsigned BufBytes = 4096;
  localparam int unsigned AddrW    = 12;
  localparam int unsigned OffW     = 14;
  localparam int unsigned HdrBytes = 10;
  localparam int unsigned MaxMsg   = 255;

  typedef enum logic [1:0] {
    OpAppend   = 2'd0,
    OpMsgByte  = 2'd1,
    OpReadByte = 2'd2,
    OpUnused   = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] stamp;
    logic [7:0]  level;
    logic [7:0]  msg_len;
    logic [7:0]  data_byte;
    logic [11:0] read_addr;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [11:0] entry_offset;
    logic [12:0] head_offset;
    logic [12:0] tail_offset;
    logic        is_empty;
    logic [7:0]  read_byte;
  } out_item_t;

  typedef enum logic [4:0] {
    CmdNone,
    CmdLoad,
    CmdPlaceEmpty,
    CmdRdNewLen,
    CmdCalcNext,
    CmdWrDummy,
    CmdOffZero,
    CmdRdOldLen,
    CmdAdvOld,
    CmdRdOldHdr,
    CmdAccHdr,
    CmdOldZero,
    CmdWrHdr,
    CmdWrPad,
    CmdCommit,
    CmdMsg,
    CmdRdUser,
    CmdResp
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [7:0] idx;
    logic       reject;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       app_bad;
    logic       left_zero;
    logic       empty;
    logic       fits;
    logic       wrapped;
    logic       overflow;
    logic       dummy_ok;
    logic       evict;
    logic       len_oob;
    logic       hdr_oob;
    logic       hdr_nz;
    logic [7:0] pad_last;
  } dp_stat_t;

  // Record span: header plus stored length, rounded up to 8 bytes.
  function automatic logic [8:0] span_of(input logic [7:0] b);
    logic [8:0] s;
    s = 9'(b) + 9'(HdrBytes + 7);
    span_of = {s[8:3], 3'b000};
  endfunction

endpackage

// ===== hw/rtl/vrt_dpath.sv =====
// Datapath of the trace ring: byte store, ring pointers, result register.
module vrt_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vrt_pkg::in_item_t  in_data_i,
  input  vrt_pkg::ctrl_cmd_t cmd_i,
  output vrt_pkg::dp_stat_t  stat_o,
  output vrt_pkg::out_item_t res_o
);

  localparam int unsigned OW = vrt_pkg::OffW;

  logic [7:0] mem [vrt_pkg::BufBytes];

  vrt_pkg::in_item_t  item_q;
  vrt_pkg::out_item_t res_q;
  logic [OW-1:0] oldest_q, newest_q, off_q;
  logic [11:0]   cursor_q;
  logic [7:0]    left_q;
  logic [7:0]    rd_q;
  logic          nz_q;

  logic [7:0]    mlen_sat, len;
  logic [OW-1:0] need, off_end, limit, buf_sz;
  logic          we, re;
  logic [OW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  assign buf_sz   = OW'(vrt_pkg::BufBytes);
  assign mlen_sat = (item_q.msg_len > 8'(vrt_pkg::MaxMsg - 1)) ?
                    8'(vrt_pkg::MaxMsg - 1) : item_q.msg_len;
  assign len      = mlen_sat + 8'd1;
  assign need     = OW'(vrt_pkg::span_of(len));
  assign off_end  = off_q + need;
  assign limit    = (newest_q < oldest_q) ? oldest_q : buf_sz;

  always_comb begin
    stat_o.opcode    = item_q.opcode;
    stat_o.app_bad   = (item_q.level == 8'd0) || (item_q.msg_len == 8'd0);
    stat_o.left_zero = (left_q == 8'd0);
    stat_o.empty     = (oldest_q >= buf_sz);
    stat_o.fits      = (off_end <= limit);
    stat_o.wrapped   = (newest_q < oldest_q);
    stat_o.overflow  = (off_end > buf_sz);
    stat_o.dummy_ok  = (off_q + OW'(vrt_pkg::HdrBytes) <= buf_sz);
    stat_o.evict     = (off_end > oldest_q);
    stat_o.len_oob   = (oldest_q + OW'(9) >= buf_sz);
    stat_o.hdr_oob   = (oldest_q + OW'(vrt_pkg::HdrBytes) > buf_sz);
    // bytes 0..8 are folded into nz_q, the last one is still in rd_q
    stat_o.hdr_nz    = nz_q | (rd_q != 8'd0);
    stat_o.pad_last  = mlen_sat;
  end

  // Store port selection
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = 8'd0;
    unique case (cmd_i.op)
      vrt_pkg::CmdWrDummy: begin
        we    = 1'b1;
        waddr = off_q + OW'(cmd_i.idx);
      end
      vrt_pkg::CmdWrHdr: begin
        we    = 1'b1;
        waddr = off_q + OW'(cmd_i.idx);
        if (cmd_i.idx < 8'd8) begin
          wdata = item_q.stamp[{cmd_i.idx[2:0], 3'b000} +: 8];
        end else if (cmd_i.idx == 8'd8) begin
          wdata = item_q.level;
        end else begin
          wdata = len;
        end
      end
      vrt_pkg::CmdWrPad: begin
        we    = 1'b1;
        waddr = off_q + OW'(vrt_pkg::HdrBytes) + OW'(cmd_i.idx);
      end
      vrt_pkg::CmdMsg: begin
        we    = 1'b1;
        waddr = OW'(cursor_q);
        wdata = item_q.data_byte;
      end
      vrt_pkg::CmdRdNewLen: begin
        re    = 1'b1;
        raddr = newest_q + OW'(9);
      end
      vrt_pkg::CmdRdOldLen: begin
        re    = 1'b1;
        raddr = oldest_q + OW'(9);
      end
      vrt_pkg::CmdRdOldHdr: begin
        re    = 1'b1;
        raddr = oldest_q + OW'(cmd_i.idx);
      end
      vrt_pkg::CmdRdUser: begin
        re    = 1'b1;
        raddr = OW'(item_q.read_addr);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we && (waddr < buf_sz)) begin
      mem[waddr[vrt_pkg::AddrW-1:0]] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr[vrt_pkg::AddrW-1:0]];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vrt_pkg::CmdLoad) begin
      item_q <= in_data_i;
    end
    unique case (cmd_i.op)
      vrt_pkg::CmdPlaceEmpty, vrt_pkg::CmdOffZero: off_q <= '0;
      vrt_pkg::CmdCalcNext: off_q <= newest_q + OW'(vrt_pkg::span_of(rd_q));
      default: begin
      end
    endcase
    if (cmd_i.op == vrt_pkg::CmdResp) begin
      res_q.status       <= cmd_i.reject;
      res_q.entry_offset <= (item_q.opcode == vrt_pkg::OpAppend && !cmd_i.reject) ?
                            off_q[11:0] : 12'd0;
      res_q.head_offset  <= oldest_q[12:0];
      res_q.tail_offset  <= newest_q[12:0];
      res_q.is_empty     <= (oldest_q >= buf_sz);
      res_q.read_byte    <= (item_q.opcode == vrt_pkg::OpReadByte && !cmd_i.reject) ?
                            rd_q : 8'd0;
    end
  end

  // Ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= OW'(vrt_pkg::BufBytes);
      newest_q <= OW'(vrt_pkg::BufBytes);
      cursor_q <= '0;
      left_q   <= '0;
      nz_q     <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        vrt_pkg::CmdPlaceEmpty, vrt_pkg::CmdOldZero: oldest_q <= '0;
        vrt_pkg::CmdAdvOld: begin
          oldest_q <= oldest_q + (stat_o.len_oob ? OW'(16) : OW'(vrt_pkg::span_of(rd_q)));
          nz_q     <= 1'b0;
        end
        // rd_q holds the header byte read in the previous cycle
        vrt_pkg::CmdRdOldHdr: begin
          if (cmd_i.idx != 8'd0) begin
            nz_q <= nz_q | (rd_q != 8'd0);
          end
        end
        vrt_pkg::CmdAccHdr: nz_q <= nz_q | (rd_q != 8'd0);
        vrt_pkg::CmdCommit: begin
          newest_q <= off_q;
          cursor_q <= 12'(off_q + OW'(vrt_pkg::HdrBytes));
          left_q   <= mlen_sat;
        end
        vrt_pkg::CmdMsg: begin
          cursor_q <= cursor_q + 12'd1;
          left_q   <= left_q - 8'd1;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_o = res_q;

endmodule

// ===== hw/rtl/vrt_ctrl.sv =====
// Sequencer of the trace ring: placement, eviction, record writes, message bytes and byte reads.
module vrt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  vrt_pkg::dp_stat_t  stat_i,
  output vrt_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    StIdle, StDispatch, StRdNew, StCalc, StDecide, StDummy, StOffZero,
    StEvChk, StRdOldLen, StAdv, StAdvChk, StHdrRd, StHdrFin, StOldZero,
    StWrHdr, StWrPad, StCommit, StMsg, StRdUser, StResp
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] cnt_q, cnt_d;
  logic       rej_q, rej_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rej_d       = rej_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '{op: vrt_pkg::CmdNone, idx: cnt_q, reject: rej_q};
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.op = vrt_pkg::CmdLoad;
          state_d  = StDispatch;
        end
      end
      StDispatch: begin
        rej_d = 1'b0;
        unique case (stat_i.opcode)
          vrt_pkg::OpAppend: begin
            if (stat_i.app_bad) begin
              rej_d   = 1'b1;
              state_d = StResp;
            end else if (stat_i.empty) begin
              cmd_o.op = vrt_pkg::CmdPlaceEmpty;
              cnt_d    = '0;
              state_d  = StWrHdr;
            end else begin
              state_d = StRdNew;
            end
          end
          vrt_pkg::OpMsgByte: begin
            if (stat_i.left_zero) begin
              rej_d   = 1'b1;
              state_d = StResp;
            end else begin
              state_d = StMsg;
            end
          end
          vrt_pkg::OpReadByte: state_d = StRdUser;
          default: begin
            rej_d   = 1'b1;
            state_d = StResp;
          end
        endcase
      end
      StRdNew: begin
        cmd_o.op = vrt_pkg::CmdRdNewLen;
        state_d  = StCalc;
      end
      StCalc: begin
        cmd_o.op = vrt_pkg::CmdCalcNext;
        state_d  = StDecide;
      end
      StDecide: begin
        cnt_d = '0;
        priority if (stat_i.fits) begin
          state_d = StWrHdr;
        end else if (stat_i.wrapped && stat_i.overflow) begin
          cmd_o.op = vrt_pkg::CmdPlaceEmpty;
          state_d  = StWrHdr;
        end else if (stat_i.wrapped) begin
          state_d = StEvChk;
        end else if (stat_i.dummy_ok) begin
          state_d = StDummy;
        end else begin
          state_d = StOffZero;
        end
      end
      StDummy: begin
        cmd_o.op = vrt_pkg::CmdWrDummy;
        cnt_d    = cnt_q + 8'd1;
        if (cnt_q == 8'(vrt_pkg::HdrBytes - 1)) begin
          state_d = StOffZero;
        end
      end
      StOffZero: begin
        cmd_o.op = vrt_pkg::CmdOffZero;
        state_d  = StEvChk;
      end
      StEvChk: begin
        cnt_d = '0;
        priority if (!stat_i.evict) begin
          state_d = StWrHdr;
        end else if (stat_i.len_oob) begin
          state_d = StAdv;
        end else begin
          state_d = StRdOldLen;
        end
      end
      StRdOldLen: begin
        cmd_o.op = vrt_pkg::CmdRdOldLen;
        state_d  = StAdv;
      end
      StAdv: begin
        cmd_o.op = vrt_pkg::CmdAdvOld;
        state_d  = StAdvChk;
      end
      StAdvChk: begin
        cnt_d   = '0;
        state_d = stat_i.hdr_oob ? StOldZero : StHdrRd;
      end
      StHdrRd: begin
        // read byte cnt while folding in the byte read last cycle
        cmd_o.op = vrt_pkg::CmdRdOldHdr;
        cnt_d    = cnt_q + 8'd1;
        if (cnt_q == 8'(vrt_pkg::HdrBytes - 1)) begin
          state_d = StHdrFin;
        end
      end
      StHdrFin: begin
        // an all-zero header past the head ends the ring
        cmd_o.op = vrt_pkg::CmdAccHdr;
        cnt_d    = '0;
        state_d  = stat_i.hdr_nz ? StEvChk : StOldZero;
      end
      StOldZero: begin
        cmd_o.op = vrt_pkg::CmdOldZero;
        cnt_d    = '0;
        state_d  = StWrHdr;
      end
      StWrHdr: begin
        cmd_o.op = vrt_pkg::CmdWrHdr;
        cnt_d    = cnt_q + 8'd1;
        if (cnt_q == 8'(vrt_pkg::HdrBytes - 1)) begin
          cnt_d   = '0;
          state_d = StWrPad;
        end
      end
      StWrPad: begin
        cmd_o.op = vrt_pkg::CmdWrPad;
        cnt_d    = cnt_q + 8'd1;
        if (cnt_q == stat_i.pad_last) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        cmd_o.op = vrt_pkg::CmdCommit;
        state_d  = StResp;
      end
      StMsg: begin
        cmd_o.op = vrt_pkg::CmdMsg;
        state_d  = StResp;
      end
      StRdUser: begin
        cmd_o.op = vrt_pkg::CmdRdUser;
        state_d  = StResp;
      end
      StResp: begin
        if (out_free) begin
          cmd_o.op    = vrt_pkg::CmdResp;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rej_q       <= rej_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/variable_record_trace_ring_unit.sv =====
// Top level of the trace ring unit: controller, datapath and checks.
//
// Input channel in_valid_i / in_stall_o carries one in_item_t per transfer;
// output channel out_valid_o / out_stall_i returns exactly one out_item_t
// per input item, in order.
// Opcodes: append header, message byte, read store byte (opcode 3 rejected).
// An append writes its header and padding into a ring with room or into an
// empty ring; it may also wrap, write a dummy header and evict records. All
// record bytes go through the single write port of the 4096-byte store,
// one a cycle. One item is in work at a time; in_stall_o is low only while
// idle, so the next item can be taken in the cycle after the result is
// loaded. A new item is taken while the previous result still waits at
// the output.
// When the receiver stalls, the result register holds and a finished item
// waits until the register frees.
// Reset empties the ring (head and tail read 4096) and clears the message
// count; store contents are undefined until written and need no clearing.
module variable_record_trace_ring_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  vrt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vrt_pkg::out_item_t out_data_o
);

  vrt_pkg::ctrl_cmd_t cmd;
  vrt_pkg::dp_stat_t  stat;

  vrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  vrt_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .res_o     (out_data_o)
  );

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |-> out_data_o.head_offset == 13'h1000)
    else $error("empty result with head not at end of store");

  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_empty |->
      out_data_o.head_offset[2:0] == 3'd0 && out_data_o.tail_offset[2:0] == 3'd0)
    else $error("record offset not 8-byte aligned");

  a_reject_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |->
      out_data_o.entry_offset == 12'd0 && out_data_o.read_byte == 8'd0)
    else $error("rejected item carries data");

endmodule
